// ===== hdl/gusf_pkg.sv =====
// Shared types and constants for the grammar useless-symbol finder.
// Used by gusf_front, gusf_queue, gusf_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package gusf_pkg;

  localparam int SYM_W         = 26;  // width of a symbol mask
  localparam int SYM_IDX_W     = 5;   // width of a symbol index
  localparam int DEF_MAX_RULES = 256;
  localparam int DEF_NUM_SYMS  = 26;
  localparam int QUEUE_DEPTH   = 4;   // must be a power of two
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int TDATA_IN_W    = 32;
  localparam int TDATA_OUT_W   = 32;

  // Classified item passed from the front to the back.
  typedef struct packed {
    logic                 has_rule;  // rule to be stored
    logic                 is_end;    // grammar ends after this item
    logic [SYM_IDX_W-1:0] left;
    logic [SYM_W-1:0]     right;
  } gusf_cmd_t;

  // One stored production.
  typedef struct packed {
    logic [SYM_IDX_W-1:0] left;
    logic [SYM_W-1:0]     right;
  } gusf_rule_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_GEN,
    S_REACH,
    S_EMIT
  } gusf_state_t;

endpackage

`default_nettype wire

// ===== hdl/gusf_front.sv =====
// Front stage: accepts input items, classifies them and holds one command
// for the queue. Depends on gusf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gusf_front #(
  parameter int NUM_SYMBOLS = gusf_pkg::DEF_NUM_SYMS
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               rule_valid,
  input  wire  [gusf_pkg::SYM_IDX_W-1:0]    left_symbol,
  input  wire  [gusf_pkg::SYM_W-1:0]        right_mask,
  input  wire                               last_rule,
  output logic                              push_valid,
  input  wire                               push_ready,
  output gusf_pkg::gusf_cmd_t               push_cmd
);
  import gusf_pkg::*;

  localparam logic [SYM_W-1:0] SymMask = SYM_W'((64'd1 << NUM_SYMBOLS) - 64'd1);

  logic      cmd_vld_r, cmd_vld_nxt;
  gusf_cmd_t cmd_r, cmd_nxt;
  logic      accept;

  assign in_ready   = !cmd_vld_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = cmd_vld_r;
  assign push_cmd   = cmd_r;

  always_comb begin
    cmd_nxt          = cmd_r;
    cmd_vld_nxt      = cmd_vld_r && !push_ready;
    if (accept) begin
      // A rule with an out-of-range left side is dropped but may still end
      // the grammar; an item that does neither is not queued at all.
      cmd_nxt.has_rule = rule_valid && (left_symbol < SYM_IDX_W'(NUM_SYMBOLS));
      cmd_nxt.is_end   = !rule_valid || last_rule;
      cmd_nxt.left     = left_symbol;
      cmd_nxt.right    = right_mask & SymMask;
      cmd_vld_nxt      = cmd_nxt.has_rule || cmd_nxt.is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= cmd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/gusf_queue.sv =====
// Short command queue between the front and the back stage.
// Depends on gusf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gusf_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push_valid,
  output logic                 push_ready,
  input  gusf_pkg::gusf_cmd_t  push_cmd,
  output logic                 pop_valid,
  input  wire                  pop_ready,
  output gusf_pkg::gusf_cmd_t  pop_cmd
);
  import gusf_pkg::*;

  gusf_cmd_t         q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = q_mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gusf_back.sv =====
// Back stage: rule store, generating and reachability passes, result register.
// Depends on gusf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gusf_back #(
  parameter int MAX_RULES   = gusf_pkg::DEF_MAX_RULES,
  parameter int NUM_SYMBOLS = gusf_pkg::DEF_NUM_SYMS
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire  [gusf_pkg::SYM_IDX_W-1:0]   start_symbol,
  input  wire                              pop_valid,
  output logic                             pop_ready,
  input  gusf_pkg::gusf_cmd_t              pop_cmd,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [gusf_pkg::SYM_W-1:0]       useless_mask,
  output logic                             rule_overflow
);
  import gusf_pkg::*;

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam logic [SYM_W-1:0] SymMask = SYM_W'((64'd1 << NUM_SYMBOLS) - 64'd1);

  gusf_rule_t       mem [MAX_RULES];
  gusf_rule_t       rd_data_r;

  gusf_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             changed_r, changed_nxt;
  logic [SYM_W-1:0] present_r, present_nxt;
  logic [SYM_W-1:0] gen_r, gen_nxt;
  logic [SYM_W-1:0] reach_r, reach_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_mask_r, out_mask_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             wr_en;
  logic [SYM_W-1:0] start_bit;
  logic [SYM_W-1:0] lb;
  logic             pass_done;
  logic             rd_issue;

  assign start_bit = (start_symbol < SYM_IDX_W'(NUM_SYMBOLS)) ?
                     (SYM_W'(1) << start_symbol) : '0;
  assign lb        = SYM_W'(1) << rd_data_r.left;
  assign pass_done = (rd_idx_r == count_r) && !rd_vld_r;
  assign rd_issue  = (rd_idx_r != count_r);

  assign pop_ready     = (state_r == S_LOAD);
  assign wr_en         = pop_valid && pop_ready && pop_cmd.has_rule &&
                         (count_r < CNT_W'(MAX_RULES));
  assign out_valid     = out_valid_r;
  assign useless_mask  = out_mask_r;
  assign rule_overflow = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = 1'b0;
    changed_nxt   = changed_r;
    present_nxt   = present_r;
    gen_nxt       = gen_r;
    reach_nxt     = reach_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_mask_nxt  = out_mask_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      S_LOAD: begin
        if (pop_valid) begin
          if (pop_cmd.has_rule) begin
            if (wr_en) begin
              count_nxt   = count_r + CNT_W'(1);
              present_nxt = present_r | (SYM_W'(1) << pop_cmd.left) | pop_cmd.right;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (pop_cmd.is_end) begin
            state_nxt   = S_GEN;
            rd_idx_nxt  = '0;
            changed_nxt = 1'b0;
            gen_nxt     = '0;
          end
        end
      end

      S_GEN: begin
        if (rd_issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r && ((gen_r & lb) == '0) && ((rd_data_r.right & ~gen_r) == '0)) begin
          gen_nxt     = gen_r | lb;
          changed_nxt = 1'b1;
        end
        // Sweep the store again until a full pass adds nothing.
        if (pass_done) begin
          rd_idx_nxt  = '0;
          changed_nxt = 1'b0;
          if (!changed_r) begin
            state_nxt = S_REACH;
            reach_nxt = start_bit;
          end
        end
      end

      S_REACH: begin
        if (rd_issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r && ((reach_r & lb) != '0) && ((gen_r & lb) != '0) &&
            ((rd_data_r.right & ~gen_r) == '0) &&
            ((rd_data_r.right & ~reach_r) != '0)) begin
          reach_nxt   = reach_r | rd_data_r.right;
          changed_nxt = 1'b1;
        end
        if (pass_done) begin
          rd_idx_nxt  = '0;
          changed_nxt = 1'b0;
          if (!changed_r) begin
            state_nxt = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = (present_r | start_bit) & (~gen_r | ~reach_r) & SymMask;
          out_ovf_nxt   = ovf_r;
          count_nxt     = '0;
          present_nxt   = '0;
          gen_nxt       = '0;
          reach_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_LOAD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      changed_r   <= 1'b0;
      present_r   <= '0;
      gen_r       <= '0;
      reach_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      changed_r   <= changed_nxt;
      present_r   <= present_nxt;
      gen_r       <= gen_nxt;
      reach_r     <= reach_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mask_r <= out_mask_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // Rule store: one write port while loading, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= '{left: pop_cmd.left, right: pop_cmd.right};
    end
    rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RULES))
    else $error("rule count beyond store depth");

  a_read_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_GEN || state_r == S_REACH))
    else $error("store read outside a pass");

  a_gen_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REACH) |=> $stable(gen_r))
    else $error("generating set changed during reachability");

  a_reach_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REACH) |=> ((reach_r & $past(reach_r)) == $past(reach_r)))
    else $error("reachable set lost a symbol");
`endif

endmodule

`default_nettype wire

// ===== hdl/grammar_useless_symbol_finder.sv =====
// After the ending item passes through the front and the queue, the rule store is swept
// repeatedly until the generating set and then the reachable set stop growing (at most
// 27 sweeps each); the result is then written into the result register.
// Throughput: one rule per cycle while loading; the sweeps run on the store's single
// read port. Synchronous low reset clears the state, sets, counts, flags, queue, held
// front command and start_symbol, but not the result mask or overflow output registers.
// Top level of the grammar useless-symbol finder.
// Depends on gusf_pkg, gusf_front, gusf_queue and gusf_back.
`timescale 1ns / 1ps
`default_nettype none

module grammar_useless_symbol_finder #(
  parameter int MAX_RULES   = gusf_pkg::DEF_MAX_RULES,
  parameter int NUM_SYMBOLS = gusf_pkg::DEF_NUM_SYMS
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [gusf_pkg::TDATA_IN_W-1:0]      in_tdata,   // left_symbol, right_mask, pad
  input  wire                                  in_tuser,   // rule_valid
  input  wire                                  in_tlast,   // last_rule
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [gusf_pkg::TDATA_OUT_W-1:0]     out_tdata,  // useless_mask, pad
  output logic                                 out_tuser,  // rule_overflow
  input  wire                                  cfg_wr_en,
  input  wire  [gusf_pkg::SYM_IDX_W-1:0]       cfg_wr_data // start_symbol
);
  import gusf_pkg::*;

  logic [SYM_IDX_W-1:0] start_r;
  gusf_cmd_t            push_cmd, pop_cmd;
  logic                 push_valid, push_ready;
  logic                 pop_valid, pop_ready;
  logic [SYM_W-1:0]     useless_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
    end else if (cfg_wr_en) begin
      start_r <= cfg_wr_data;
    end
  end

  gusf_front #(
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .rule_valid  (in_tuser),
    .left_symbol (in_tdata[SYM_IDX_W-1:0]),
    .right_mask  (in_tdata[SYM_IDX_W+SYM_W-1:SYM_IDX_W]),
    .last_rule   (in_tlast),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  gusf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  gusf_back #(
    .MAX_RULES   (MAX_RULES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .start_symbol  (start_r),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_cmd       (pop_cmd),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .useless_mask  (useless_mask),
    .rule_overflow (out_tuser)
  );

  assign out_tdata = TDATA_OUT_W'(useless_mask);

endmodule

`default_nettype wire
